@@ sv/slab_bitmap_allocator_top_macros.svh @@
// Assertion macros shared by the slab bitmap allocator top level.
`ifndef SLAB_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define SLAB_BITMAP_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never be seen at a clock edge out of reset.
`define SBA_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ sv/sba_pkg.sv @@
// Shared types, constants and size-class tables of the slab bitmap allocator.
package sba_pkg;

    localparam int OBJECTS_PER_CLASS = 512;
    localparam int CLASS_COUNT       = 6;
    localparam int REG_COUNT         = 6;
    localparam int MAX_OBJ_BYTES     = 256;
    localparam int BITS_PER_WORD     = 64;
    localparam int BIT_SEL_W         = 6;
    localparam int WORD_SEL_W        = 6;
    localparam int ADDR_W            = 32;
    localparam int SIZE_W            = 32;
    localparam int CLS_W             = 3;
    localparam int BYTES_W           = 9;
    localparam int STATUS_W          = 3;
    localparam int CFG_IDX_W         = 3;
    localparam int QUEUE_DEPTH       = 2;

    // Reciprocal of five for the 160-byte class: exact for quotients of
    // values below two to the power RECIP5_SHIFT.
    localparam int RECIP5       = 52429;
    localparam int RECIP5_W     = 16;
    localparam int RECIP5_SHIFT = 18;

    localparam logic [CLS_W-1:0] CLS_160 = 3'd4;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED   = 3'd0,
        ST_FREED       = 3'd1,
        ST_TOO_LARGE   = 3'd2,
        ST_FULL        = 3'd3,
        ST_NOT_IN_SLAB = 3'd4,
        ST_MISALIGNED  = 3'd5,
        ST_NULL        = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CMD_REPLY = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        status_t                status;
        logic [CLS_W-1:0]       cls;
        logic [BYTES_W-1:0]     bytes;
        logic [ADDR_W-1:0]      base;
        logic [WORD_SEL_W-1:0]  word;
        logic [BIT_SEL_W-1:0]   bit_sel;
    } cmd_t;

    typedef struct packed {
        status_t                status;
        logic [ADDR_W-1:0]      object_address;
        logic [CLS_W-1:0]       class_index;
        logic [BYTES_W-1:0]     object_bytes;
    } rsp_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

    function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLS_W-1:0] cls);
        logic [BYTES_W-1:0] r;
        unique case (cls)
            3'd0:    r = 9'd16;
            3'd1:    r = 9'd32;
            3'd2:    r = 9'd64;
            3'd3:    r = 9'd128;
            3'd4:    r = 9'd160;
            3'd5:    r = 9'd256;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Shift that takes a byte offset to an object index, before the
    // division by five of the 160-byte class.
    function automatic logic [3:0] class_shift(input logic [CLS_W-1:0] cls);
        logic [3:0] r;
        unique case (cls)
            3'd0:    r = 4'd4;
            3'd1:    r = 4'd5;
            3'd2:    r = 4'd6;
            3'd3:    r = 4'd7;
            3'd4:    r = 4'd5;
            3'd5:    r = 4'd8;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/sba_channels.sv @@
// Handshake channel interfaces of the slab bitmap allocator.
interface sba_req_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [sba_pkg::SIZE_W-1:0]  request_size;
    logic [sba_pkg::ADDR_W-1:0]  free_address;

    modport source (output valid, opcode, request_size, free_address, input ready);
    modport sink   (input valid, opcode, request_size, free_address, output ready);
endinterface

interface sba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sba_pkg::STATUS_W-1:0]  status;
    logic [sba_pkg::ADDR_W-1:0]    object_address;
    logic [sba_pkg::CLS_W-1:0]     class_index;
    logic [sba_pkg::BYTES_W-1:0]   object_bytes;

    modport source (output valid, status, object_address, class_index, object_bytes,
                    input ready);
    modport sink   (input valid, status, object_address, class_index, object_bytes,
                    output ready);
endinterface

interface sba_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sba_pkg::CFG_IDX_W-1:0]  index;
    logic [sba_pkg::ADDR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/slab_bitmap_allocator_top.sv @@
// Top level of the slab bitmap allocator: front end, command queue and back end.
// Throughput: the front end takes one request word at a time and classifies it before the next;
// the back end's scan reads one bitmap word per cycle.
// Reset: bases clear to zero and a pass of one cycle per bitmap word zeroes the bitmap.
`include "slab_bitmap_allocator_top_macros.svh"

module slab_bitmap_allocator_top #(
    parameter int OBJECTS_PER_CLASS = sba_pkg::OBJECTS_PER_CLASS,
    parameter int CLASS_COUNT       = sba_pkg::CLASS_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    sba_cfg_if.sink     cfg,
    sba_req_if.sink     req,
    sba_rsp_if.source   rsp
);

    // Commands travelling from the front end into the queue.
    sba_pkg::cmd_t        push_data;
    logic                 push_valid;
    logic                 push_ready;

    // Commands leaving the queue towards the back end.
    sba_pkg::cmd_t        pop_data;
    logic                 pop_valid;
    logic                 pop_ready;

    // The back end reports whether it is still zeroing the bitmap after reset.
    sba_pkg::back_stat_t  back_stat;

    // The front end holds the class base registers, takes one request word at a time,
    // picks the size class and, for a free, works out the object index and alignment.
    // Requests that need no bitmap access are turned into ready-made replies here.
    sba_front #(
        .OBJECTS_PER_CLASS (OBJECTS_PER_CLASS),
        .CLASS_COUNT       (CLASS_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req        (req),
        .clearing   (back_stat.clearing),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // The queue lets the front end classify the next word while the back end
    // is still scanning the bitmap for the one before.
    sba_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // The back end owns the bitmap RAM. It claims the lowest free object of a class,
    // forms the object address with one multiply and one add, releases freed objects
    // and keeps the result in an output register, so it can take the next command
    // while a result still waits to be taken.
    sba_back #(
        .OBJECTS_PER_CLASS (OBJECTS_PER_CLASS),
        .CLASS_COUNT       (CLASS_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .stat      (back_stat),
        .rsp       (rsp)
    );

    // No request word may enter while the bitmap is still being zeroed.
    `SBA_ASSERT_NEVER(a_no_accept_in_clear, back_stat.clearing && req.ready, "request taken during clear")
    // Only an allocation carries an object address.
    `SBA_ASSERT_IMPLY(a_addr_only_alloc, rsp.valid && (rsp.status != sba_pkg::ST_ALLOCATED), rsp.object_address == '0, "address on a non-allocation result")
    // An allocation always names a class that exists.
    `SBA_ASSERT_IMPLY(a_alloc_class, rsp.valid && (rsp.status == sba_pkg::ST_ALLOCATED), int'(rsp.class_index) < CLASS_COUNT, "allocation from a missing class")
    // Nothing can be waiting at the output when the clearing pass ends.
    `SBA_ASSERT_IMPLY(a_clear_quiet, $fell(back_stat.clearing), !rsp.valid, "result present at end of clear")

endmodule

@@ sv/sba_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module sba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 48
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/sba_front.sv @@
// Front end: holds the class bases, accepts words and classifies them into commands.
module sba_front #(
    parameter int OBJECTS_PER_CLASS = sba_pkg::OBJECTS_PER_CLASS,
    parameter int CLASS_COUNT       = sba_pkg::CLASS_COUNT
) (
    input  logic           clk,
    input  logic           rst_n,
    sba_cfg_if.sink        cfg,
    sba_req_if.sink        req,
    input  logic           clearing,
    output sba_pkg::cmd_t  push_data,
    output logic           push_valid,
    input  logic           push_ready
);

    localparam int IDX_W  = $clog2(OBJECTS_PER_CLASS);
    localparam int OFF_W  = $clog2(sba_pkg::MAX_OBJ_BYTES * OBJECTS_PER_CLASS);
    localparam int PROD_W = OFF_W + sba_pkg::RECIP5_W;
    localparam int CLS_W  = sba_pkg::CLS_W;
    localparam int ADDR_W = sba_pkg::ADDR_W;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CLASS,
        F_INDEX,
        F_PUSH
    } fstate_t;

    fstate_t                 state_reg, state_next;
    sba_pkg::opcode_t        op_reg, op_next;
    logic [ADDR_W-1:0]       req_size_reg, req_size_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [CLS_W-1:0]        cls_reg, cls_next;
    logic [OFF_W-1:0]        off_reg, off_next;
    sba_pkg::cmd_t           cmd_reg, cmd_next;
    logic [ADDR_W-1:0]       base_reg [CLASS_COUNT];

    logic                    fit_found;
    logic [CLS_W-1:0]        fit_cls;
    logic [ADDR_W-1:0]       fit_base;
    logic                    hit_found;
    logic [CLS_W-1:0]        hit_cls;
    logic [ADDR_W-1:0]       hit_off;

    logic [3:0]              shift;
    logic                    five;
    logic [OFF_W-1:0]        shifted;
    logic [OFF_W-1:0]        low_mask;
    logic [PROD_W-1:0]       prod5;
    logic [OFF_W-1:0]        quot5;
    logic [OFF_W-1:0]        rem5;
    logic                    aligned;
    logic [IDX_W-1:0]        obj_idx;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                base_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                if (cfg.valid && cfg.ready && (int'(cfg.index) == c) &&
                    (c < sba_pkg::REG_COUNT))
                begin
                    base_reg[c] <= cfg.data;
                end
            end
        end
    end

    // First class whose object size covers the request.
    always_comb
    begin
        fit_found = 1'b0;
        fit_cls   = '0;
        fit_base  = '0;
        for (int c = CLASS_COUNT - 1; c >= 0; c--)
        begin
            if ((sba_pkg::class_bytes(CLS_W'(c)) != '0) &&
                (req_size_reg <= ADDR_W'(sba_pkg::class_bytes(CLS_W'(c)))))
            begin
                fit_found = 1'b1;
                fit_cls   = CLS_W'(c);
                fit_base  = base_reg[c];
            end
        end
    end

    // Lowest present class whose region holds the address.
    always_comb
    begin
        hit_found = 1'b0;
        hit_cls   = '0;
        hit_off   = '0;
        for (int c = CLASS_COUNT - 1; c >= 0; c--)
        begin
            if ((sba_pkg::class_bytes(CLS_W'(c)) != '0) && (base_reg[c] != '0) &&
                (addr_reg >= base_reg[c]) &&
                ((addr_reg - base_reg[c]) <
                 ADDR_W'(int'(sba_pkg::class_bytes(CLS_W'(c))) * OBJECTS_PER_CLASS)))
            begin
                hit_found = 1'b1;
                hit_cls   = CLS_W'(c);
                hit_off   = addr_reg - base_reg[c];
            end
        end
    end

    // Object index and alignment of the offset within the matched class.
    always_comb
    begin
        shift    = sba_pkg::class_shift(cls_reg);
        five     = (cls_reg == sba_pkg::CLS_160);
        shifted  = off_reg >> shift;
        low_mask = (OFF_W'(1) << shift) - OFF_W'(1);
        prod5    = PROD_W'(shifted) * PROD_W'(sba_pkg::RECIP5);
        quot5    = OFF_W'(prod5 >> sba_pkg::RECIP5_SHIFT);
        rem5     = shifted - ((quot5 << 2) + quot5);
        aligned  = ((off_reg & low_mask) == '0) && (!five || (rem5 == '0));
        obj_idx  = five ? IDX_W'(quot5) : IDX_W'(shifted);
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        req_size_next = req_size_reg;
        addr_next     = addr_reg;
        cls_next      = cls_reg;
        off_next      = off_reg;
        cmd_next      = cmd_reg;
        req.ready     = (state_reg == F_IDLE) && !clearing;
        push_valid    = (state_reg == F_PUSH);

        unique case (state_reg)
            F_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    op_next       = sba_pkg::opcode_t'(req.opcode);
                    req_size_next = req.request_size;
                    addr_next     = req.free_address;
                    state_next    = F_CLASS;
                end
            end
            F_CLASS:
            begin
                cmd_next = '0;
                if (op_reg == sba_pkg::OP_ALLOC)
                begin
                    state_next = F_PUSH;
                    if (!fit_found)
                    begin
                        cmd_next.kind   = sba_pkg::CMD_REPLY;
                        cmd_next.status = sba_pkg::ST_TOO_LARGE;
                    end
                    else
                    begin
                        cmd_next.cls   = fit_cls;
                        cmd_next.bytes = sba_pkg::class_bytes(fit_cls);
                        if (fit_base == '0)
                        begin
                            cmd_next.kind   = sba_pkg::CMD_REPLY;
                            cmd_next.status = sba_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd_next.kind   = sba_pkg::CMD_ALLOC;
                            cmd_next.status = sba_pkg::ST_ALLOCATED;
                            cmd_next.base   = fit_base;
                        end
                    end
                end
                else if (addr_reg == '0)
                begin
                    cmd_next.kind   = sba_pkg::CMD_REPLY;
                    cmd_next.status = sba_pkg::ST_NULL;
                    state_next      = F_PUSH;
                end
                else if (!hit_found)
                begin
                    cmd_next.kind   = sba_pkg::CMD_REPLY;
                    cmd_next.status = sba_pkg::ST_NOT_IN_SLAB;
                    state_next      = F_PUSH;
                end
                else
                begin
                    cls_next   = hit_cls;
                    off_next   = OFF_W'(hit_off);
                    state_next = F_INDEX;
                end
            end
            F_INDEX:
            begin
                cmd_next       = '0;
                cmd_next.cls   = cls_reg;
                cmd_next.bytes = sba_pkg::class_bytes(cls_reg);
                if (aligned)
                begin
                    cmd_next.kind    = sba_pkg::CMD_FREE;
                    cmd_next.status  = sba_pkg::ST_FREED;
                    cmd_next.word    = sba_pkg::WORD_SEL_W'(obj_idx >> sba_pkg::BIT_SEL_W);
                    cmd_next.bit_sel = sba_pkg::BIT_SEL_W'(obj_idx);
                end
                else
                begin
                    cmd_next.kind   = sba_pkg::CMD_REPLY;
                    cmd_next.status = sba_pkg::ST_MISALIGNED;
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            op_reg       <= sba_pkg::OP_ALLOC;
            req_size_reg <= '0;
            addr_reg     <= '0;
            cls_reg      <= '0;
            off_reg      <= '0;
            cmd_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            req_size_reg <= req_size_next;
            addr_reg     <= addr_next;
            cls_reg      <= cls_next;
            off_reg      <= off_next;
            cmd_reg      <= cmd_next;
        end
    end

    assign push_data = cmd_reg;

endmodule

@@ sv/sba_queue.sv @@
// Short command queue between the front end and the back end.
module sba_queue #(
    parameter int DEPTH = sba_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  sba_pkg::cmd_t  push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output sba_pkg::cmd_t  pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sba_pkg::cmd_t   entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

@@ sv/sba_back.sv @@
// Back end: owns the used bitmap, scans, claims and releases objects, drives results.
module sba_back #(
    parameter int OBJECTS_PER_CLASS = sba_pkg::OBJECTS_PER_CLASS,
    parameter int CLASS_COUNT       = sba_pkg::CLASS_COUNT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sba_pkg::cmd_t        pop_data,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    output sba_pkg::back_stat_t  stat,
    sba_rsp_if.source            rsp
);

    localparam int WPC    = OBJECTS_PER_CLASS / sba_pkg::BITS_PER_WORD;
    localparam int DEPTH  = CLASS_COUNT * WPC;
    localparam int MEM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = $clog2(OBJECTS_PER_CLASS);
    localparam int WC_W   = $clog2(WPC + 1);
    localparam int WI_W   = (WPC > 1) ? $clog2(WPC) : 1;
    localparam int PROD_W = IDX_W + sba_pkg::BYTES_W;
    localparam int BW     = sba_pkg::BITS_PER_WORD;
    localparam int ADDR_W = sba_pkg::ADDR_W;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_SCAN,
        B_FREE_WR,
        B_MUL,
        B_SUM,
        B_EMIT
    } bstate_t;

    bstate_t              state_reg, state_next;
    logic [MEM_AW-1:0]    clr_reg, clr_next;
    sba_pkg::cmd_t        cmd_reg, cmd_next;
    logic [WC_W-1:0]      rd_w_reg, rd_w_next;
    logic [WI_W-1:0]      chk_w_reg, chk_w_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    sba_pkg::rsp_t        result_reg, result_next;
    sba_pkg::rsp_t        out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 ram_we, ram_re;
    logic [MEM_AW-1:0]    ram_waddr, ram_raddr;
    logic [BW-1:0]        ram_wdata, ram_rdata;
    logic [sba_pkg::BIT_SEL_W-1:0] free_bit;

    function automatic logic [MEM_AW-1:0] word_addr(input logic [sba_pkg::CLS_W-1:0] cls,
                                                    input int w);
        return MEM_AW'(int'(cls) * WPC + w);
    endfunction

    function automatic logic [sba_pkg::BIT_SEL_W-1:0] lowest_zero(input logic [BW-1:0] v);
        logic [sba_pkg::BIT_SEL_W-1:0] r;
        r = '0;
        for (int i = BW - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                r = sba_pkg::BIT_SEL_W'(i);
            end
        end
        return r;
    endfunction

    sba_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign free_bit      = lowest_zero(ram_rdata);
    assign stat.clearing = (state_reg == B_CLEAR);
    assign pop_ready     = (state_reg == B_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        rd_w_next      = rd_w_reg;
        chk_w_next     = chk_w_reg;
        chk_valid_next = chk_valid_reg;
        idx_next       = idx_reg;
        prod_next      = prod_reg;
        result_next    = result_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + MEM_AW'(1);
                if (clr_reg == MEM_AW'(DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    cmd_next = pop_data;
                    unique case (pop_data.kind)
                        sba_pkg::CMD_ALLOC:
                        begin
                            rd_w_next      = '0;
                            chk_valid_next = 1'b0;
                            state_next     = B_SCAN;
                        end
                        sba_pkg::CMD_FREE:
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = word_addr(pop_data.cls, int'(pop_data.word));
                            state_next = B_FREE_WR;
                        end
                        default:
                        begin
                            result_next.status         = pop_data.status;
                            result_next.object_address = '0;
                            result_next.class_index    = pop_data.cls;
                            result_next.object_bytes   = pop_data.bytes;
                            state_next                 = B_EMIT;
                        end
                    endcase
                end
            end
            B_SCAN:
            begin
                // Reads run one word ahead of the check of the word before.
                if (rd_w_reg < WC_W'(WPC))
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = word_addr(cmd_reg.cls, int'(rd_w_reg));
                    rd_w_next      = rd_w_reg + WC_W'(1);
                    chk_w_next     = WI_W'(rd_w_reg);
                    chk_valid_next = 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
                if (chk_valid_reg)
                begin
                    if (~ram_rdata != '0)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = word_addr(cmd_reg.cls, int'(chk_w_reg));
                        ram_wdata  = ram_rdata | (BW'(1) << free_bit);
                        idx_next   = IDX_W'(int'(chk_w_reg) * BW + int'(free_bit));
                        state_next = B_MUL;
                    end
                    else if (chk_w_reg == WI_W'(WPC - 1))
                    begin
                        result_next.status         = sba_pkg::ST_FULL;
                        result_next.object_address = '0;
                        result_next.class_index    = cmd_reg.cls;
                        result_next.object_bytes   = cmd_reg.bytes;
                        state_next                 = B_EMIT;
                    end
                end
            end
            B_FREE_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = word_addr(cmd_reg.cls, int'(cmd_reg.word));
                ram_wdata = ram_rdata & ~(BW'(1) << cmd_reg.bit_sel);
                result_next.status         = sba_pkg::ST_FREED;
                result_next.object_address = '0;
                result_next.class_index    = cmd_reg.cls;
                result_next.object_bytes   = cmd_reg.bytes;
                state_next                 = B_EMIT;
            end
            B_MUL:
            begin
                prod_next  = PROD_W'(idx_reg) * PROD_W'(cmd_reg.bytes);
                state_next = B_SUM;
            end
            B_SUM:
            begin
                result_next.status         = sba_pkg::ST_ALLOCATED;
                result_next.object_address = cmd_reg.base + ADDR_W'(prod_reg);
                result_next.class_index    = cmd_reg.cls;
                result_next.object_bytes   = cmd_reg.bytes;
                state_next                 = B_EMIT;
            end
            B_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = result_reg;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            cmd_reg       <= '0;
            rd_w_reg      <= '0;
            chk_w_reg     <= '0;
            chk_valid_reg <= 1'b0;
            idx_reg       <= '0;
            prod_reg      <= '0;
            result_reg    <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cmd_reg       <= cmd_next;
            rd_w_reg      <= rd_w_next;
            chk_w_reg     <= chk_w_next;
            chk_valid_reg <= chk_valid_next;
            idx_reg       <= idx_next;
            prod_reg      <= prod_next;
            result_reg    <= result_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.object_address = out_reg.object_address;
    assign rsp.class_index    = out_reg.class_index;
    assign rsp.object_bytes   = out_reg.object_bytes;

endmodule
